[src/mfs_pkg.sv]
// Shared types and constants for the multilevel feedback scheduler.
// No dependencies; imported by mfs_queue and the top level.
package mfs_pkg;

    // Field widths of the request and result words
    localparam int REQ_W     = 2;
    localparam int ID_W      = 4;
    localparam int OUTCOME_W = 2;
    localparam int RLEVEL_W  = 2;
    localparam int TICKS_W   = 10;
    localparam int SLICE_W   = 8;

    // Slice unit after reset
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    // Request codes; any other code acts as a plain reschedule
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESCHED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXIT    = 2'd2;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_OK      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NO_SLOT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NONE    = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_HALTED  = 2'd3;

    // Per-cycle command to one ready queue
    typedef struct packed {
        logic push;
        logic pop;
    } mfs_qctl_t;

endpackage

[src/mfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by mfs_queue for the ready queue storage.
module mfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/mfs_queue.sv]
// One ready queue: circular buffer in mfs_ram plus a cached head entry.
// Depends on mfs_pkg (mfs_qctl_t) and mfs_ram.
module mfs_queue #(
    parameter int IW    = 4,
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfs_pkg::mfs_qctl_t ctl,
    input  logic [IW-1:0]     push_data,
    output logic              nonempty,
    output logic [IW-1:0]     pop_data
);
    import mfs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] hv_reg, hv_next;
    logic          fwd_hit_reg, fwd_hit_next;
    logic [IW-1:0] fwd_data_reg;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] waddr, raddr;
    logic [IW-1:0] rdata, second;
    logic          push_eff;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        wrap_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    assign nonempty = (count_reg != '0);
    // An empty queue hands a same-cycle push straight through
    assign pop_data = nonempty ? hv_reg : push_data;
    assign push_eff = ctl.push && (count_reg < CW'(DEPTH));

    always_comb begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
    end
    assign waddr = tail_sum[AW-1:0];

    assign second = fwd_hit_reg ? fwd_data_reg : rdata;

    always_comb begin
        head_next  = ctl.pop ? wrap_inc(head_reg) : head_reg;
        count_next = count_reg + CW'(push_eff) - CW'(ctl.pop);
        hv_next    = hv_reg;
        if (ctl.pop) begin
            hv_next = (count_reg > CW'(1)) ? second : push_data;
        end else if (!nonempty && push_eff) begin
            hv_next = push_data;
        end
    end

    // Read ahead the entry behind the next head; forward a colliding write
    assign raddr        = wrap_inc(head_next);
    assign fwd_hit_next = push_eff && (waddr == raddr);

    mfs_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (push_eff),
        .waddr (waddr),
        .wdata (push_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        hv_reg       <= hv_next;
        fwd_data_reg <= push_data;
    end

endmodule

[src/multilevel_feedback_scheduler_unit.sv]
// Top level of the multilevel feedback task scheduler.
// Depends on mfs_pkg and mfs_queue (one per priority level).
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+---------------------------
//  s_      | s_valid s_ready s_req_type s_slice_used | one request word
//  m_      | m_valid m_ready m_task_id m_outcome     | one result word per request
//          | m_switched m_run_level m_slice_ticks    |
//  cfg_    | cfg_we cfg_wdata                        | slice unit, no handshake
//
// A request word is held in the input register, decided combinationally and
// lands in the result register; one word per cycle while m_ side is not stalled.
// The rate is set by the single decision pass and the queue head caches.
// Reset is synchronous, active low; all queues come up empty, no task runs.
// A stalled m_ side holds the result and the input register; s_ready then
// drops once the input register is full.
module multilevel_feedback_scheduler_unit #(
    parameter int TASK_SLOTS = 16,
    parameter int LEVELS     = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mfs_pkg::SLICE_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mfs_pkg::REQ_W-1:0]         s_req_type,
    input  logic                              s_slice_used,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mfs_pkg::ID_W-1:0]          m_task_id,
    output logic [mfs_pkg::OUTCOME_W-1:0]     m_outcome,
    output logic                              m_switched,
    output logic [mfs_pkg::RLEVEL_W-1:0]      m_run_level,
    output logic [mfs_pkg::TICKS_W-1:0]       m_slice_ticks
);
    import mfs_pkg::*;

    localparam int TW = $clog2(TASK_SLOTS);   // task index width
    localparam int PW = $clog2(LEVELS);       // queue index width
    localparam int LW = $clog2(LEVELS + 1);   // level number width (1..LEVELS)
    localparam int MW = LW + SLICE_W;         // slice product width

    // Input register
    logic             in_valid_reg;
    logic [REQ_W-1:0] req_reg;
    logic             used_reg;
    logic             advance;

    // Scheduler state
    logic [TASK_SLOTS-1:0] slot_used_reg, slot_used_next;
    logic [TW-1:0]         cur_task_reg, cur_task_next;
    logic [LW-1:0]         cur_level_reg, cur_level_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic                  halted_reg, halted_next;
    logic [SLICE_W-1:0]    slice_unit_reg;

    // Result register
    logic                 m_valid_reg;
    logic [ID_W-1:0]      task_id_reg, task_id_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;
    logic                 switched_reg, switched_next;
    logic [RLEVEL_W-1:0]  run_level_reg, run_level_next;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;

    // Queue side
    mfs_qctl_t     q_ctl       [LEVELS];
    logic [TW-1:0] q_push_data [LEVELS];
    logic [TW-1:0] q_pop_data  [LEVELS];
    logic [LEVELS-1:0] q_nonempty, q_push, q_pop, q_avail;

    // Decision terms
    logic          free_found;
    logic [TW-1:0] free_slot;
    logic          create_push;
    logic          pick_found;
    logic [PW-1:0] pick;
    logic          do_resched, dying, dropping;
    logic [LW-1:0] requeue_level;
    logic [TW-1:0] res_id;
    logic [MW-1:0] ticks_prod;

    // Take a new word whenever the result register is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = TW'(i);
            end
        end
    end

    assign create_push = !halted_reg && (req_reg == REQ_CREATE) && free_found;

    // First non-empty queue, counting the slot that create pushes at level 1
    always_comb begin
        q_avail    = q_nonempty;
        q_avail[0] = q_nonempty[0] | create_push;
        pick_found = 1'b0;
        pick       = '0;
        for (int q = LEVELS - 1; q >= 0; q--) begin
            if (q_avail[q]) begin
                pick_found = 1'b1;
                pick       = PW'(q);
            end
        end
    end

    always_comb begin
        slot_used_next = slot_used_reg;
        cur_task_next  = cur_task_reg;
        cur_level_next = cur_level_reg;
        cur_valid_next = cur_valid_reg;
        halted_next    = halted_reg;
        q_push         = '0;
        q_pop          = '0;
        do_resched     = 1'b0;
        dying          = 1'b0;
        dropping       = 1'b0;
        requeue_level  = cur_level_reg;
        res_id         = '0;
        outcome_next   = OUT_OK;
        switched_next  = 1'b0;

        if (halted_reg) begin
            outcome_next = OUT_HALTED;
        end else begin
            case (req_reg)
                REQ_CREATE: begin
                    if (!free_found) begin
                        outcome_next = OUT_NO_SLOT;
                    end else begin
                        slot_used_next[free_slot] = 1'b1;
                        q_push[0] = 1'b1;
                        res_id    = free_slot;
                        // Preempt a worse-level task, or start one if idle
                        if (!cur_valid_reg || cur_level_reg > LW'(1)) begin
                            do_resched = 1'b1;
                        end
                    end
                end
                REQ_EXIT: begin
                    if (!cur_valid_reg) begin
                        outcome_next = OUT_NONE;
                    end else if (cur_task_reg == '0) begin
                        halted_next  = 1'b1;
                        outcome_next = OUT_HALTED;
                    end else begin
                        do_resched = 1'b1;
                        dying      = 1'b1;
                    end
                end
                default: begin
                    do_resched = 1'b1;
                    dropping   = (req_reg == REQ_RESCHED) && used_reg;
                end
            endcase
        end

        if (do_resched) begin
            if (!pick_found) begin
                outcome_next = OUT_NONE;
                if (dying) begin
                    slot_used_next[cur_task_reg] = 1'b0;
                    cur_valid_next = 1'b0;
                end
            end else begin
                if (cur_valid_reg) begin
                    if (dying) begin
                        slot_used_next[cur_task_reg] = 1'b0;
                    end else begin
                        // Drop one level when the slice ran out
                        if (dropping && cur_level_reg < LW'(LEVELS)) begin
                            requeue_level = cur_level_reg + LW'(1);
                        end
                        q_push[PW'(requeue_level - LW'(1))] = 1'b1;
                    end
                end
                q_pop[pick]    = 1'b1;
                cur_task_next  = q_pop_data[pick];
                cur_level_next = LW'(pick) + LW'(1);
                cur_valid_next = 1'b1;
                switched_next  = !(cur_valid_reg && !dying &&
                                   cur_task_reg == q_pop_data[pick]);
            end
        end

        if (!advance) begin
            q_push = '0;
            q_pop  = '0;
        end
    end

    // Result fields describe the task running after this request; a create reports the new task's id
    assign ticks_prod = MW'(cur_level_next) * MW'(slice_unit_reg);

    always_comb begin
        task_id_next   = ID_W'(res_id);
        run_level_next = '0;
        ticks_next     = '0;
        if (outcome_next != OUT_HALTED && cur_valid_next) begin
            if (req_reg != REQ_CREATE) begin
                task_id_next = ID_W'(cur_task_next);
            end
            run_level_next = RLEVEL_W'(cur_level_next);
            ticks_next     = ticks_prod[TICKS_W-1:0];
        end
        if (outcome_next == OUT_HALTED) begin
            task_id_next = '0;
        end
    end

    // One ready queue per level; create feeds level 1, requeues feed any level
    for (genvar q = 0; q < LEVELS; q++) begin : g_queue
        assign q_ctl[q].push  = q_push[q];
        assign q_ctl[q].pop   = q_pop[q];
        assign q_push_data[q] = (q == 0 && create_push) ? free_slot : cur_task_reg;

        mfs_queue #(
            .IW    (TW),
            .DEPTH (TASK_SLOTS)
        ) u_queue (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (q_ctl[q]),
            .push_data (q_push_data[q]),
            .nonempty  (q_nonempty[q]),
            .pop_data  (q_pop_data[q])
        );
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            slot_used_reg  <= '0;
            cur_task_reg   <= '0;
            cur_level_reg  <= LW'(1);
            cur_valid_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            slice_unit_reg <= SLICE_RESET;
        end else begin
            if (cfg_we) begin
                slice_unit_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg   <= 1'b1;
                slot_used_reg <= slot_used_next;
                cur_task_reg  <= cur_task_next;
                cur_level_reg <= cur_level_next;
                cur_valid_reg <= cur_valid_next;
                halted_reg    <= halted_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the request word and the result word
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg  <= s_req_type;
            used_reg <= s_slice_used;
        end
        if (advance) begin
            task_id_reg   <= task_id_next;
            outcome_reg   <= outcome_next;
            switched_reg  <= switched_next;
            run_level_reg <= run_level_next;
            ticks_reg     <= ticks_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_task_id     = task_id_reg;
    assign m_outcome     = outcome_reg;
    assign m_switched    = switched_reg;
    assign m_run_level   = run_level_reg;
    assign m_slice_ticks = ticks_reg;

endmodule
